// ===== hdl/cross_entropy_loss_grad_core_assert.svh =====
// Assertion macros for the cross-entropy loss and gradient core.
`ifndef CROSS_ENTROPY_LOSS_GRAD_CORE_ASSERT_SVH
`define CROSS_ENTROPY_LOSS_GRAD_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, sampled on i_clk and idle while i_rst_n is low.
`define CELG_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("celg assertion failed: same-cycle implication");
// Next-cycle implication, sampled on i_clk and idle while i_rst_n is low.
`define CELG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("celg assertion failed: next-cycle implication");
`else
`define CELG_ASSERT_IMPL(label, ante, cons)
`define CELG_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== hdl/celg_pkg.sv =====
// Shared types and constants of the cross-entropy loss and gradient core.
`timescale 1ns / 1ps
package celg_pkg;

    localparam int PROB_W = 17;
    localparam int GRAD_W = 33;
    localparam int LOSS_W = 32;
    localparam int EXP_W  = 5;
    localparam int MANT_W = 31;
    localparam int FRAC_W = 24;
    localparam int QUO_W  = 32;
    localparam int N_W    = 29;
    localparam int PROD_W = 45;
    localparam int TERM_W = 21;
    localparam int CNT_W  = 5;

    localparam logic [31:0] LN2_Q32   = 32'hB172_17F8;
    localparam logic [31:0] LOSS_MAX  = 32'hFFFF_FFFF;
    localparam logic [32:0] GRAD_SAT  = 33'h1_0000_0000;
    localparam logic [61:0] ROUND_BIT = 62'(1) << 39;

    // Step numbers inside the iteration phase.
    localparam logic [CNT_W-1:0] LOG_STEPS = 5'd24;
    localparam logic [CNT_W-1:0] STEP_N    = 5'd24;
    localparam logic [CNT_W-1:0] STEP_MLO  = 5'd25;
    localparam logic [CNT_W-1:0] STEP_MHI  = 5'd26;
    localparam logic [CNT_W-1:0] STEP_TERM = 5'd27;
    localparam logic [CNT_W-1:0] ITER_LAST = 5'd31;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ITER,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic div_step;
        logic log_step;
        logic make_n;
        logic mul_lo;
        logic mul_hi;
        logic term;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic needs_calc;
    } t_stat;

endpackage

// ===== hdl/cross_entropy_loss_grad_core.sv =====
// Top level of the streaming cross-entropy loss and gradient core.
// A target-one element with nonzero probability runs the 32-step reciprocal divider and the log2
// squaring search, then a commit step; other elements go straight to the commit step.
// The core takes no new element until the current one has committed.
// A waiting result lets the next element transfer in.
// Synchronous active-low reset clears the controller, the loss sum and the error flag.
`timescale 1ns / 1ps
module cross_entropy_loss_grad_core #(
    parameter int PROB_FRAC_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [celg_pkg::PROB_W-1:0]         i_probability,
    input  logic                                i_target_is_one,
    input  logic                                i_last_in_sample,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [celg_pkg::GRAD_W-1:0]  o_gradient,
    output logic [celg_pkg::LOSS_W-1:0]         o_sample_loss,
    output logic                                o_loss_valid,
    output logic                                o_zero_probability
);

    celg_pkg::t_cmd  cmd;
    celg_pkg::t_stat stat;

    celg_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    celg_dpath #(
        .PROB_FRAC_BITS (PROB_FRAC_BITS)
    ) u_dpath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_stat             (stat),
        .i_probability      (i_probability),
        .i_target_is_one    (i_target_is_one),
        .i_last_in_sample   (i_last_in_sample),
        .o_gradient         (o_gradient),
        .o_sample_loss      (o_sample_loss),
        .o_loss_valid       (o_loss_valid),
        .o_zero_probability (o_zero_probability)
    );

endmodule

// ===== hdl/celg_dpath.sv =====
// Datapath: reciprocal divider, log2 squaring unit, ln2 scaling and loss accumulator.
`timescale 1ns / 1ps
module celg_dpath #(
    parameter int PROB_FRAC_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  celg_pkg::t_cmd                i_cmd,
    output celg_pkg::t_stat               o_stat,
    input  logic [celg_pkg::PROB_W-1:0]   i_probability,
    input  logic                          i_target_is_one,
    input  logic                          i_last_in_sample,
    output logic signed [celg_pkg::GRAD_W-1:0] o_gradient,
    output logic [celg_pkg::LOSS_W-1:0]   o_sample_loss,
    output logic                          o_loss_valid,
    output logic                          o_zero_probability
);

    localparam int SHIFT_TOT = 16 + PROB_FRAC_BITS;
    localparam logic [31:0] ONE_VAL = 32'(1) << PROB_FRAC_BITS;
    localparam int SAT_SH = (PROB_FRAC_BITS >= 16) ? PROB_FRAC_BITS - 16 : 0;
    localparam logic [celg_pkg::PROB_W-1:0] SAT_LIM =
        (PROB_FRAC_BITS >= 16) ? (celg_pkg::PROB_W'(1) << SAT_SH) : '0;
    localparam int DVD_SH = (SHIFT_TOT < 32) ? SHIFT_TOT : 0;
    localparam logic [celg_pkg::QUO_W-1:0] DVD_INIT =
        (SHIFT_TOT < 32) ? (celg_pkg::QUO_W'(1) << DVD_SH) : '0;
    localparam int REM_SH = (SHIFT_TOT >= 32) ? SHIFT_TOT - 32 : 0;
    localparam logic [celg_pkg::PROB_W-1:0] REM_INIT =
        (SHIFT_TOT >= 32) ? (celg_pkg::PROB_W'(1) << REM_SH) : '0;
    localparam logic [celg_pkg::EXP_W-1:0] FRAC_EXP = celg_pkg::EXP_W'(PROB_FRAC_BITS);

    logic [celg_pkg::PROB_W-1:0] p_clamp;
    logic [celg_pkg::EXP_W-1:0]  e_in;
    logic [celg_pkg::MANT_W-1:0] m_in;

    logic                         r_tgt, r_last, r_zero, r_sat;
    logic [celg_pkg::PROB_W-1:0]  r_p;
    logic [celg_pkg::EXP_W-1:0]   r_fe;
    logic [celg_pkg::MANT_W-1:0]  r_m;
    logic [celg_pkg::FRAC_W-1:0]  r_frac;
    logic [celg_pkg::PROB_W-1:0]  r_rem;
    logic [celg_pkg::QUO_W-1:0]   r_dvd;
    logic [celg_pkg::QUO_W-1:0]   r_quo;
    logic [celg_pkg::N_W-1:0]     r_n;
    logic [celg_pkg::PROD_W-1:0]  r_plo, r_phi;
    logic [celg_pkg::TERM_W-1:0]  r_term;
    logic [celg_pkg::LOSS_W-1:0]  r_loss_sum;
    logic                         r_err;
    logic signed [celg_pkg::GRAD_W-1:0] r_grad;
    logic [celg_pkg::LOSS_W-1:0]  r_sloss;
    logic                         r_lvalid, r_zprob;

    logic [celg_pkg::PROB_W:0]    div_try;
    logic                         div_ge;
    logic [61:0]                  sq;
    logic [31:0]                  sq_top;
    logic [15:0]                  mul_b;
    logic [celg_pkg::PROD_W-1:0]  mul_p;
    logic [61:0]                  scaled;
    logic [celg_pkg::LOSS_W-1:0]  term_add;
    logic [celg_pkg::LOSS_W:0]    acc;
    logic [celg_pkg::LOSS_W-1:0]  acc_sat;
    logic                         err_new;
    logic [celg_pkg::GRAD_W-1:0]  mag;
    logic [celg_pkg::GRAD_W-1:0]  grad;

    // Clamp to 1.0, then find the leading one to normalize into Q1.30.
    always_comb begin
        p_clamp = ({15'd0, i_probability} > ONE_VAL) ? ONE_VAL[celg_pkg::PROB_W-1:0]
                                                    : i_probability;
        e_in = '0;
        for (int k = 0; k < celg_pkg::PROB_W; k++) begin
            if (p_clamp[k]) begin
                e_in = celg_pkg::EXP_W'(k);
            end
        end
        m_in = celg_pkg::MANT_W'(p_clamp) << (5'd30 - e_in);
    end

    assign o_stat.needs_calc = i_target_is_one && (i_probability != '0);

    // One restoring division step; the dividend is a single power of two.
    assign div_try = {r_rem, r_dvd[celg_pkg::QUO_W-1]};
    assign div_ge  = div_try >= {1'b0, r_p};

    // One squaring step of the log2 fraction search.
    assign sq     = r_m * r_m;
    assign sq_top = sq[61:30];

    assign mul_b  = i_cmd.mul_hi ? celg_pkg::LN2_Q32[31:16] : celg_pkg::LN2_Q32[15:0];
    assign mul_p  = r_n * mul_b;
    assign scaled = {1'b0, r_phi, 16'd0} + {17'd0, r_plo} + celg_pkg::ROUND_BIT;

    always_comb begin
        if (!r_tgt) begin
            term_add = '0;
        end else if (r_zero) begin
            term_add = celg_pkg::LOSS_MAX;
        end else begin
            term_add = celg_pkg::LOSS_W'(r_term);
        end
        acc     = {1'b0, r_loss_sum} + {1'b0, term_add};
        acc_sat = acc[celg_pkg::LOSS_W] ? celg_pkg::LOSS_MAX : acc[celg_pkg::LOSS_W-1:0];
        err_new = r_err | (r_tgt & r_zero);
        mag     = r_sat ? celg_pkg::GRAD_SAT : {1'b0, r_quo};
        grad    = r_tgt ? (celg_pkg::GRAD_W'(0) - mag) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_tgt  <= i_target_is_one;
            r_last <= i_last_in_sample;
            r_zero <= (i_probability == '0);
            r_sat  <= (p_clamp <= SAT_LIM);
            r_p    <= p_clamp;
            r_fe   <= FRAC_EXP - e_in;
            r_m    <= m_in;
            r_frac <= '0;
            r_rem  <= REM_INIT;
            r_dvd  <= DVD_INIT;
            r_quo  <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem <= div_ge ? celg_pkg::PROB_W'(div_try - {1'b0, r_p})
                            : div_try[celg_pkg::PROB_W-1:0];
            r_quo <= {r_quo[celg_pkg::QUO_W-2:0], div_ge};
            r_dvd <= {r_dvd[celg_pkg::QUO_W-2:0], 1'b0};
        end
        if (i_cmd.log_step) begin
            // A square of 2.0 or more yields a fraction bit of one and is halved.
            r_m    <= sq_top[31] ? sq_top[31:1] : sq_top[30:0];
            r_frac <= {r_frac[celg_pkg::FRAC_W-2:0], sq_top[31]};
        end
        if (i_cmd.make_n) begin
            r_n <= {r_fe, 24'd0} - {5'd0, r_frac};
        end
        if (i_cmd.mul_lo) begin
            r_plo <= mul_p;
        end
        if (i_cmd.mul_hi) begin
            r_phi <= mul_p;
        end
        if (i_cmd.term) begin
            r_term <= scaled[60:40];
        end
        if (i_cmd.commit) begin
            r_grad   <= grad;
            r_sloss  <= r_last ? acc_sat : '0;
            r_lvalid <= r_last;
            r_zprob  <= err_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loss_sum <= '0;
            r_err      <= 1'b0;
        end else if (i_cmd.commit) begin
            r_loss_sum <= r_last ? '0 : acc_sat;
            r_err      <= r_last ? 1'b0 : err_new;
        end
    end

    assign o_gradient         = r_grad;
    assign o_sample_loss      = r_sloss;
    assign o_loss_valid       = r_lvalid;
    assign o_zero_probability = r_zprob;

endmodule

// ===== hdl/celg_ctrl.sv =====
// Controller: sequences the datapath steps and owns both handshakes.
`timescale 1ns / 1ps
`include "cross_entropy_loss_grad_core_assert.svh"
module celg_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    output logic              o_valid,
    input  logic              i_ready,
    input  celg_pkg::t_stat   i_stat,
    output celg_pkg::t_cmd    o_cmd
);

    celg_pkg::t_state                r_state, n_state;
    logic [celg_pkg::CNT_W-1:0]      r_cnt, n_cnt;
    logic                            r_o_valid, n_o_valid;
    logic                            iter_done;

    assign iter_done = (r_state == celg_pkg::ST_ITER) && (r_cnt == celg_pkg::ITER_LAST);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= celg_pkg::ST_IDLE;
            r_cnt     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_o_valid <= n_o_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            celg_pkg::ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = i_stat.needs_calc ? celg_pkg::ST_ITER : celg_pkg::ST_DONE;
                end
            end
            celg_pkg::ST_ITER: begin
                o_cmd.div_step = 1'b1;
                o_cmd.log_step = (r_cnt < celg_pkg::LOG_STEPS);
                o_cmd.make_n   = (r_cnt == celg_pkg::STEP_N);
                o_cmd.mul_lo   = (r_cnt == celg_pkg::STEP_MLO);
                o_cmd.mul_hi   = (r_cnt == celg_pkg::STEP_MHI);
                o_cmd.term     = (r_cnt == celg_pkg::STEP_TERM);
                n_cnt          = r_cnt + 1'b1;
                if (iter_done) begin
                    n_state = celg_pkg::ST_DONE;
                end
            end
            celg_pkg::ST_DONE: begin
                // The result register must be empty or emptying this cycle.
                if (!r_o_valid || i_ready) begin
                    o_cmd.commit = 1'b1;
                    n_state      = celg_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = celg_pkg::ST_IDLE;
            end
        endcase
        n_o_valid = o_cmd.commit ? 1'b1 : (i_ready ? 1'b0 : r_o_valid);
    end

    assign o_valid = r_o_valid;

    `CELG_ASSERT_IMPL(a_commit_slot_free, o_cmd.commit, !r_o_valid || i_ready)
    `CELG_ASSERT_NEXT(a_commit_out, o_cmd.commit, r_o_valid && (r_state == celg_pkg::ST_IDLE))
    `CELG_ASSERT_NEXT(a_iter_ends, iter_done, r_state == celg_pkg::ST_DONE)

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the streaming cross-entropy loss and gradient core.
`timescale 1ns / 1ps
module testbench;

    localparam int FRAC_BITS    = 16;
    localparam int ONE_Q        = 1 << FRAC_BITS;
    localparam int PHASE_ITEMS  = 420;
    localparam int STALL_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 80;
    localparam int REPORT_MAX   = 10;

    typedef struct {
        logic [celg_pkg::PROB_W-1:0] prob;
        logic                        hot;
        logic                        last;
    } t_element;

    typedef struct {
        logic [celg_pkg::GRAD_W-1:0] grad;
        logic [celg_pkg::LOSS_W-1:0] loss;
        logic                        loss_valid;
        logic                        zero_prob;
    } t_grad_loss;

    logic                               i_clk;
    logic                               i_rst_n;
    logic                               i_valid;
    logic                               o_ready;
    logic [celg_pkg::PROB_W-1:0]        i_probability;
    logic                               i_target_is_one;
    logic                               i_last_in_sample;
    logic                               o_valid;
    logic                               i_ready;
    logic signed [celg_pkg::GRAD_W-1:0] o_gradient;
    logic [celg_pkg::LOSS_W-1:0]        o_sample_loss;
    logic                               o_loss_valid;
    logic                               o_zero_probability;

    t_element   elem_q[$];
    t_grad_loss grad_loss_q[$];

    // Running state of the predictor.
    logic [celg_pkg::LOSS_W-1:0] sum_q16;
    logic                        saw_zero_prob;

    int  send_idle_pct;
    int  ready_idle_pct;
    int  fail_count;
    int  stall_cycles;
    bit  in_taken;

    cross_entropy_loss_grad_core #(
        .PROB_FRAC_BITS(FRAC_BITS)
    ) DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_probability      (i_probability),
        .i_target_is_one    (i_target_is_one),
        .i_last_in_sample   (i_last_in_sample),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_gradient         (o_gradient),
        .o_sample_loss      (o_sample_loss),
        .o_loss_valid       (o_loss_valid),
        .o_zero_probability (o_zero_probability)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // -ln(p) in Q16.16 for 1 <= p <= 1.0: log2 by repeated squaring, then scaled by ln 2.
    function automatic logic [31:0] minus_ln_q16(input logic [celg_pkg::PROB_W-1:0] p);
        int          top;
        logic [63:0] mant;
        logic [63:0] frac;
        logic [63:0] nq;
        logic [63:0] prod;
        top = 0;
        for (int b = 0; b < celg_pkg::PROB_W; b++) begin
            if (p[b]) top = b;
        end
        mant = 64'(p) << (30 - top);
        frac = '0;
        for (int k = 1; k <= 24; k++) begin
            mant = (mant * mant) >> 30;
            if (mant >= 64'h8000_0000) begin
                mant = mant >> 1;
                frac[24-k] = 1'b1;
            end
        end
        nq = (64'(FRAC_BITS - top) << 24) - frac;
        prod = nq * 64'(celg_pkg::LN2_Q32);
        return 32'((prod + (64'd1 << 39)) >> 40);
    endfunction

    task automatic predict_element(input t_element e);
        logic [celg_pkg::PROB_W-1:0] p;
        logic [63:0]                 mag;
        logic [63:0]                 term;
        logic [63:0]                 acc;
        t_grad_loss                  r;
        p = (e.prob > ONE_Q) ? celg_pkg::PROB_W'(ONE_Q) : e.prob;
        mag = '0;
        if (e.hot) begin
            if (p == '0) begin
                mag = 64'(celg_pkg::GRAD_SAT);
                term = 64'(celg_pkg::LOSS_MAX);
                saw_zero_prob = 1'b1;
            end else begin
                mag = (64'd1 << (16 + FRAC_BITS)) / 64'(p);
                if (mag > 64'(celg_pkg::GRAD_SAT)) mag = 64'(celg_pkg::GRAD_SAT);
                term = 64'(minus_ln_q16(p));
            end
            acc = 64'(sum_q16) + term;
            sum_q16 = (acc > 64'(celg_pkg::LOSS_MAX)) ? celg_pkg::LOSS_MAX : acc[31:0];
        end
        r.grad       = celg_pkg::GRAD_W'(64'd0 - mag);
        r.loss       = e.last ? sum_q16 : '0;
        r.loss_valid = e.last;
        r.zero_prob  = saw_zero_prob;
        grad_loss_q.push_back(r);
        if (e.last) begin
            sum_q16 = '0;
            saw_zero_prob = 1'b0;
        end
    endtask

    function automatic void queue_element(input int p, input bit hot, input bit last);
        t_element e;
        e.prob = celg_pkg::PROB_W'(p);
        e.hot  = hot;
        e.last = last;
        elem_q.push_back(e);
    endfunction

    function automatic int random_probability();
        case ($urandom_range(19))
            0:       return 0;
            1:       return $urandom_range(1, 255);
            2:       return $urandom_range(65280, ONE_Q);
            3:       return $urandom_range(ONE_Q + 1, (1 << celg_pkg::PROB_W) - 1);
            4:       return ONE_Q;
            5:       return $urandom_range(0, (1 << celg_pkg::PROB_W) - 1);
            default: return $urandom_range(1, ONE_Q - 1);
        endcase
    endfunction

    // Mostly one-hot samples; some carry no hot target or several.
    function automatic int add_random_sample();
        int len;
        int hot_at;
        bit hot;
        len = ($urandom_range(9) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 6);
        hot_at = $urandom_range(0, len - 1);
        for (int k = 0; k < len; k++) begin
            hot = ($urandom_range(99) < 85) ? (k == hot_at) : 1'($urandom_range(1));
            queue_element(random_probability(), hot, k == len - 1);
        end
        return len;
    endfunction

    // Driver: a new element goes out only after the previous transfer has completed.
    always @(negedge i_clk) begin : drive
        bit       hold;
        t_element e;
        hold = i_valid && !in_taken;
        in_taken = 1'b0;
        i_ready <= ($urandom_range(99) >= ready_idle_pct);
        if (!hold) begin
            if (i_rst_n && elem_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                e = elem_q.pop_front();
                i_probability    <= e.prob;
                i_target_is_one  <= e.hot;
                i_last_in_sample <= e.last;
                i_valid          <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Monitor: predicts on every input transfer and checks every result transfer.
    always @(posedge i_clk) begin : monitor
        t_element   e;
        t_grad_loss want;
        bit         in_fire;
        bit         out_fire;
        in_fire  = i_rst_n && i_valid && o_ready;
        out_fire = i_rst_n && o_valid && i_ready;
        if (in_fire) begin
            e.prob = i_probability;
            e.hot  = i_target_is_one;
            e.last = i_last_in_sample;
            predict_element(e);
            in_taken = 1'b1;
        end
        if (out_fire) begin
            if (grad_loss_q.size() == 0) begin
                fail_count++;
                if (fail_count <= REPORT_MAX)
                    $display("unexpected result: grad %0d loss %0d", o_gradient, o_sample_loss);
            end else begin
                want = grad_loss_q.pop_front();
                if (o_gradient !== want.grad || o_sample_loss !== want.loss ||
                    o_loss_valid !== want.loss_valid ||
                    o_zero_probability !== want.zero_prob) begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX) begin
                        $display("mismatch: grad exp %0d got %0d, loss exp %0d got %0d",
                                 $signed(want.grad), o_gradient, want.loss, o_sample_loss);
                        $display("  loss_valid exp %0b got %0b, zero_prob exp %0b got %0b",
                                 want.loss_valid, o_loss_valid,
                                 want.zero_prob, o_zero_probability);
                    end
                end
            end
        end
        if (!i_rst_n || in_fire || out_fire) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("watchdog: no transfer in %0d cycles", STALL_LIMIT);
                $display("status: fail");
                $finish;
            end
        end
    end

    initial begin
        int made;
        i_rst_n          = 1'b0;
        i_valid          = 1'b0;
        i_ready          = 1'b0;
        i_probability    = '0;
        i_target_is_one  = 1'b0;
        i_last_in_sample = 1'b0;
        sum_q16          = '0;
        saw_zero_prob    = 1'b0;
        fail_count       = 0;
        stall_cycles     = 0;
        send_idle_pct    = 26;
        ready_idle_pct   = 50;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin send_idle_pct = 26; ready_idle_pct = 50; end
                1: begin send_idle_pct = 50; ready_idle_pct = 26; end
                default: begin send_idle_pct = 0; ready_idle_pct = 0; end
            endcase
            if (phase == 0) begin
                // Single-element samples at the edges of the probability range.
                queue_element(0, 1, 1);
                queue_element(0, 0, 1);
                queue_element(1, 1, 1);
                queue_element(2, 1, 1);
                queue_element(ONE_Q - 1, 1, 1);
                queue_element(ONE_Q, 1, 1);
                queue_element(ONE_Q + 1, 1, 1);
                queue_element((1 << celg_pkg::PROB_W) - 1, 1, 1);
                // Multi-element sample with a cold element above one.
                queue_element((1 << celg_pkg::PROB_W) - 1, 0, 0);
                queue_element(21845, 1, 0);
                queue_element(32768, 0, 1);
                // A zero probability saturates the sum and flags the rest of the sample.
                queue_element(0, 1, 0);
                queue_element(100, 1, 0);
                queue_element(40000, 0, 1);
                // Several large terms summed in one sample.
                queue_element(1, 1, 0);
                queue_element(1, 1, 0);
                queue_element(1, 1, 1);
                queue_element(32768, 1, 1);
                queue_element(43690, 0, 0);
                queue_element(43691, 1, 1);
            end
            made = 0;
            while (made < PHASE_ITEMS)
                made += add_random_sample();
            while (elem_q.size() != 0 || i_valid)
                @(posedge i_clk);
        end

        while (grad_loss_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
